FILE: src/pi_position_loop_with_settle_assert.svh
`ifndef PI_POSITION_LOOP_WITH_SETTLE_ASSERT_SVH
`define PI_POSITION_LOOP_WITH_SETTLE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PIPLS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// next-cycle implication, checked outside reset
`define PIPLS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

FILE: src/pipls_pkg.sv
package pipls_pkg;

	localparam int SAMPLE_BITS = 10;
	localparam int DRIVE_BITS  = 8;
	localparam int GAIN_FRAC   = 8;
	localparam int GAIN_BITS   = 16;
	localparam int COUNT_BITS  = 8;

	localparam int ERR_BITS   = SAMPLE_BITS + 1;
	localparam int LIMIT_BITS = DRIVE_BITS + GAIN_FRAC;
	localparam int ACC_BITS   = LIMIT_BITS + 1;
	localparam int PROD_BITS  = GAIN_BITS + 1 + ERR_BITS;
	localparam int SUM_BITS   = ((PROD_BITS > ACC_BITS) ? PROD_BITS : ACC_BITS) + 1;

	localparam int IDX_BITS = 3;
	localparam int CFG_BITS = (GAIN_BITS >= SAMPLE_BITS && GAIN_BITS >= DRIVE_BITS) ? GAIN_BITS :
		((SAMPLE_BITS >= DRIVE_BITS) ? SAMPLE_BITS : DRIVE_BITS);

	localparam int IN_DATA_BITS  = ((2 * SAMPLE_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_BITS = ((DRIVE_BITS + 2 + 7) / 8) * 8;
	localparam int OUT_REV_BIT   = DRIVE_BITS;
	localparam int OUT_REL_BIT   = DRIVE_BITS + 1;

	localparam int PROP_GAIN_RST   = 256;
	localparam int INT_GAIN_RST    = 0;
	localparam int DRIVE_LIMIT_RST = 255;
	localparam int SETTLE_THR_RST  = 50;
	localparam int SETTLE_CNT_RST  = 12;

	typedef enum logic [IDX_BITS-1:0] {
		REG_ENABLE         = 3'd0,
		REG_PROP_GAIN      = 3'd1,
		REG_INT_GAIN       = 3'd2,
		REG_DRIVE_LIMIT    = 3'd3,
		REG_SETTLE_THR     = 3'd4,
		REG_SETTLE_SAMPLES = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic                   enable;
		logic [GAIN_BITS-1:0]   prop_gain;
		logic [GAIN_BITS-1:0]   int_gain;
		logic [DRIVE_BITS-1:0]  drive_limit;
		logic [SAMPLE_BITS-1:0] settle_thr;
		logic [COUNT_BITS-1:0]  settle_samples;
	} cfg_t;

	typedef struct packed {
		logic signed [ACC_BITS-1:0] integral;
		logic [SAMPLE_BITS:0]       prev_target;
		logic                       released;
		logic [COUNT_BITS-1:0]      period_cnt;
		logic [SAMPLE_BITS:0]       settle_ref;
		logic [DRIVE_BITS-1:0]      drv_mag;
		logic                       drv_pos;
	} state_t;

	typedef struct packed {
		logic [DRIVE_BITS-1:0] drive_level;
		logic                  drive_reverse;
		logic                  motor_released;
	} result_t;

	localparam cfg_t CFG_RESET = '{
		enable:         1'b1,
		prop_gain:      GAIN_BITS'(PROP_GAIN_RST),
		int_gain:       GAIN_BITS'(INT_GAIN_RST),
		drive_limit:    DRIVE_BITS'(DRIVE_LIMIT_RST),
		settle_thr:     SAMPLE_BITS'(SETTLE_THR_RST),
		settle_samples: COUNT_BITS'(SETTLE_CNT_RST)
	};

	localparam state_t STATE_RESET = '{
		integral:    '0,
		prev_target: '1,
		released:    1'b0,
		period_cnt:  '0,
		settle_ref:  '1,
		drv_mag:     '0,
		drv_pos:     1'b0
	};

	function automatic logic signed [ACC_BITS-1:0] clamp_sym(
		input logic signed [SUM_BITS-1:0] v,
		input logic signed [ACC_BITS-1:0] b
	);
		logic signed [SUM_BITS-1:0] b_w;
		b_w = b;
		if (v > b_w)
			return b;
		else if (v < -b_w)
			return -b;
		else
			return ACC_BITS'(v);
	endfunction

	function automatic logic [SAMPLE_BITS:0] abs_diff(
		input logic [SAMPLE_BITS:0] a,
		input logic [SAMPLE_BITS:0] b
	);
		return (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

FILE: src/pipls_calc.sv
module pipls_calc (
	input  logic [pipls_pkg::SAMPLE_BITS-1:0] position,
	input  logic [pipls_pkg::SAMPLE_BITS-1:0] target,
	input  pipls_pkg::cfg_t                   cfg,
	input  pipls_pkg::state_t                 st,
	output pipls_pkg::state_t                 st_next,
	output pipls_pkg::result_t                res
);

	logic signed [pipls_pkg::ERR_BITS-1:0]  err;
	logic signed [pipls_pkg::ACC_BITS-1:0]  bound;
	logic signed [pipls_pkg::PROD_BITS-1:0] int_prod;
	logic signed [pipls_pkg::PROD_BITS-1:0] prop_prod;
	logic signed [pipls_pkg::SUM_BITS-1:0]  int_sum;
	logic signed [pipls_pkg::SUM_BITS-1:0]  drv_sum;
	logic signed [pipls_pkg::ACC_BITS-1:0]  int_new;
	logic signed [pipls_pkg::ACC_BITS-1:0]  drv_clamp;
	logic [pipls_pkg::LIMIT_BITS-1:0]       drv_abs;
	logic [pipls_pkg::DRIVE_BITS-1:0]       mag;
	logic [pipls_pkg::SAMPLE_BITS:0]        pos_w;
	logic [pipls_pkg::SAMPLE_BITS:0]        tgt_w;
	logic [pipls_pkg::SAMPLE_BITS:0]        thr_w;
	logic [pipls_pkg::COUNT_BITS-1:0]       cnt_inc;
	logic                                   hit;
	logic                                   settled;
	logic                                   rel;

	assign pos_w = {1'b0, position};
	assign tgt_w = {1'b0, target};
	assign thr_w = {1'b0, cfg.settle_thr};
	assign err   = $signed(tgt_w) - $signed(pos_w);
	assign bound = $signed(pipls_pkg::ACC_BITS'(cfg.drive_limit) << pipls_pkg::GAIN_FRAC);

	assign int_prod  = $signed({1'b0, cfg.int_gain}) * err;
	assign prop_prod = $signed({1'b0, cfg.prop_gain}) * err;
	assign int_sum   = int_prod + st.integral;
	assign int_new   = pipls_pkg::clamp_sym(int_sum, bound);
	assign drv_sum   = prop_prod + int_new;
	assign drv_clamp = pipls_pkg::clamp_sym(drv_sum, bound);

	// truncate toward zero: shift the magnitude, keep the sign apart
	assign drv_abs = drv_clamp[pipls_pkg::ACC_BITS-1] ?
		pipls_pkg::LIMIT_BITS'(-drv_clamp) : pipls_pkg::LIMIT_BITS'(drv_clamp);
	assign mag = drv_abs[pipls_pkg::LIMIT_BITS-1:pipls_pkg::GAIN_FRAC];

	assign cnt_inc = st.period_cnt + 1'b1;
	assign hit     = (cnt_inc == cfg.settle_samples);
	assign settled = (pipls_pkg::abs_diff(st.settle_ref, pos_w) <= thr_w) &&
		(pipls_pkg::abs_diff(st.settle_ref, tgt_w) < thr_w) &&
		(pipls_pkg::abs_diff(pos_w, tgt_w) < thr_w);

	always_comb begin
		st_next = st;
		rel     = st.released;
		if (cfg.enable) begin
			if (st.prev_target != tgt_w) begin
				rel                 = 1'b0;
				st_next.prev_target = tgt_w;
			end
			st_next.released = rel;
			if (!rel) begin
				st_next.integral   = int_new;
				st_next.drv_mag    = mag;
				st_next.drv_pos    = !drv_clamp[pipls_pkg::ACC_BITS-1] && (mag != '0);
				st_next.period_cnt = hit ? '0 : cnt_inc;
				if (hit) begin
					st_next.settle_ref = pos_w;
					if (settled)
						st_next.released = 1'b1;
				end
			end
		end
	end

	always_comb begin
		res.motor_released = st_next.released;
		res.drive_level    = st_next.released ? '0 : st_next.drv_mag;
		res.drive_reverse  = !st_next.released && st_next.drv_pos;
	end

endmodule

FILE: src/pi_position_loop_with_settle.sv
// channel  | side   | word fields (low bit first)
// s_axis   | in     | position[9:0], target[19:10], zero pad to 24 bits
// m_axis   | out    | drive_level[7:0], drive_reverse[8], motor_released[9], pad to 16
// cfg      | in     | cfg_addr selects register, cfg_wdata written when cfg_we
//
// One word per cycle sustained while the output is not stalled; words pass an input and a result register.
// The PI update and settle check are combinational from the input register, and the loop
// state register updates as the result is captured, so it is ready for the next word.
// Reset loads default registers and the reset loop state (previous target, settle reference all ones) at once.
// A stalled result holds and backs up into the input register only.
module pi_position_loop_with_settle (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [pipls_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,   // position, target
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [pipls_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,   // level, reverse, released
	input  logic                                 cfg_we,
	input  logic [pipls_pkg::IDX_BITS-1:0]       cfg_addr,
	input  logic [pipls_pkg::CFG_BITS-1:0]       cfg_wdata
);

	pipls_pkg::cfg_t                   cfg_q;
	pipls_pkg::state_t                 st_q;
	pipls_pkg::state_t                 st_next;
	pipls_pkg::result_t                res;
	pipls_pkg::result_t                res_s2;
	logic                              vld_s1;
	logic                              vld_s2;
	logic [pipls_pkg::SAMPLE_BITS-1:0] pos_s1;
	logic [pipls_pkg::SAMPLE_BITS-1:0] tgt_s1;
	logic                              adv;
	logic                              take;

	assign adv           = !vld_s2 || m_axis_tready;
	assign s_axis_tready = !vld_s1 || adv;
	assign take          = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= pipls_pkg::CFG_RESET;
		end else if (cfg_we) begin
			unique case (pipls_pkg::reg_idx_t'(cfg_addr))
				pipls_pkg::REG_ENABLE: begin
					cfg_q.enable <= cfg_wdata[0];
				end
				pipls_pkg::REG_PROP_GAIN: begin
					cfg_q.prop_gain <= cfg_wdata[pipls_pkg::GAIN_BITS-1:0];
				end
				pipls_pkg::REG_INT_GAIN: begin
					cfg_q.int_gain <= cfg_wdata[pipls_pkg::GAIN_BITS-1:0];
				end
				pipls_pkg::REG_DRIVE_LIMIT: begin
					cfg_q.drive_limit <= cfg_wdata[pipls_pkg::DRIVE_BITS-1:0];
				end
				pipls_pkg::REG_SETTLE_THR: begin
					cfg_q.settle_thr <= cfg_wdata[pipls_pkg::SAMPLE_BITS-1:0];
				end
				pipls_pkg::REG_SETTLE_SAMPLES: begin
					cfg_q.settle_samples <= cfg_wdata[pipls_pkg::COUNT_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pos_s1 <= s_axis_tdata[pipls_pkg::SAMPLE_BITS-1:0];
			tgt_s1 <= s_axis_tdata[2*pipls_pkg::SAMPLE_BITS-1:pipls_pkg::SAMPLE_BITS];
		end
		if (vld_s1 && adv)
			res_s2 <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			st_q   <= pipls_pkg::STATE_RESET;
		end else begin
			if (s_axis_tready)
				vld_s1 <= s_axis_tvalid;
			if (adv)
				vld_s2 <= vld_s1;
			if (vld_s1 && adv)
				st_q <= st_next;
		end
	end

	pipls_calc u_calc (
		.position (pos_s1),
		.target   (tgt_s1),
		.cfg      (cfg_q),
		.st       (st_q),
		.st_next  (st_next),
		.res      (res)
	);

	assign m_axis_tvalid = vld_s2;
	assign m_axis_tdata  = pipls_pkg::OUT_DATA_BITS'({res_s2.motor_released,
		res_s2.drive_reverse, res_s2.drive_level});

endmodule

FILE: src/pipls_checker.sv
`include "pi_position_loop_with_settle_assert.svh"

module pipls_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                m_axis_tvalid,
	input logic                                m_axis_tready,
	input logic [pipls_pkg::OUT_DATA_BITS-1:0] m_axis_tdata
);

	`PIPLS_ASSERT_NXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

	// a released motor shows no drive
	`PIPLS_ASSERT_IMP(a_rel_quiet, clk, arst_n, m_axis_tvalid && m_axis_tdata[pipls_pkg::OUT_REL_BIT], m_axis_tdata[pipls_pkg::OUT_REL_BIT-1:0] == '0)

	// reverse flag only with a nonzero level
	`PIPLS_ASSERT_IMP(a_rev_level, clk, arst_n, m_axis_tvalid && m_axis_tdata[pipls_pkg::OUT_REV_BIT], m_axis_tdata[pipls_pkg::DRIVE_BITS-1:0] != '0)

endmodule

bind pi_position_loop_with_settle pipls_checker u_pipls_checker (.*);

FILE: dv/tb_pi_position_loop_with_settle.sv
`timescale 1ns / 1ps

module tb_pi_position_loop_with_settle;

	localparam int CYCLE_LIMIT = 200000;

	logic                                clk;
	logic                                arst_n;
	logic                                s_axis_tvalid;
	logic                                s_axis_tready;
	logic [pipls_pkg::IN_DATA_BITS-1:0]  s_axis_tdata;   // position[9:0], target[19:10], zero pad
	logic                                m_axis_tvalid;
	logic                                m_axis_tready;
	logic [pipls_pkg::OUT_DATA_BITS-1:0] m_axis_tdata;   // drive_level[7:0], drive_reverse[8],
	                                                     // motor_released[9], zero pad
	logic                                cfg_we;
	logic [pipls_pkg::IDX_BITS-1:0]      cfg_addr;
	logic [pipls_pkg::CFG_BITS-1:0]      cfg_wdata;

	pi_position_loop_with_settle dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	typedef struct packed {
		logic [pipls_pkg::SAMPLE_BITS-1:0] pos;
		logic [pipls_pkg::SAMPLE_BITS-1:0] tgt;
		bit                                typed;
		logic [pipls_pkg::DRIVE_BITS-1:0]  lvl;
		bit                                rev;
		bit                                rel;
	} dir_row_t;

	// default config: unity prop gain, no integral, settle check every 12 periods
	localparam dir_row_t DIR_ROWS [26] = '{
		'{10'd0,    10'd1023, 1'b1, 8'd255, 1'b1, 1'b0},
		'{10'd1023, 10'd0,    1'b1, 8'd255, 1'b0, 1'b0},
		'{10'd512,  10'd512,  1'b1, 8'd0,   1'b0, 1'b0},
		'{10'd100,  10'd110,  1'b1, 8'd10,  1'b1, 1'b0},
		'{10'd110,  10'd100,  1'b1, 8'd10,  1'b0, 1'b0},
		'{10'd1023, 10'd1023, 1'b1, 8'd0,   1'b0, 1'b0},
		'{10'd0,    10'd0,    1'b1, 8'd0,   1'b0, 1'b0},
		// first check fails against the unset reference, then takes 595
		'{10'd595,  10'd600,  1'b0, 8'd0,   1'b0, 1'b0},
		'{10'd595,  10'd600,  1'b0, 8'd0,   1'b0, 1'b0},
		'{10'd595,  10'd600,  1'b0, 8'd0,   1'b0, 1'b0},
		'{10'd595,  10'd600,  1'b0, 8'd0,   1'b0, 1'b0},
		'{10'd595,  10'd600,  1'b0, 8'd0,   1'b0, 1'b0},
		// second check passes on the last of these
		'{10'd598,  10'd600,  1'b0, 8'd0,   1'b0, 1'b0},
		'{10'd598,  10'd600,  1'b0, 8'd0,   1'b0, 1'b0},
		'{10'd598,  10'd600,  1'b0, 8'd0,   1'b0, 1'b0},
		'{10'd598,  10'd600,  1'b0, 8'd0,   1'b0, 1'b0},
		'{10'd598,  10'd600,  1'b0, 8'd0,   1'b0, 1'b0},
		'{10'd598,  10'd600,  1'b0, 8'd0,   1'b0, 1'b0},
		'{10'd598,  10'd600,  1'b0, 8'd0,   1'b0, 1'b0},
		'{10'd598,  10'd600,  1'b0, 8'd0,   1'b0, 1'b0},
		'{10'd598,  10'd600,  1'b0, 8'd0,   1'b0, 1'b0},
		'{10'd598,  10'd600,  1'b0, 8'd0,   1'b0, 1'b0},
		'{10'd598,  10'd600,  1'b0, 8'd0,   1'b0, 1'b0},
		'{10'd598,  10'd600,  1'b0, 8'd0,   1'b0, 1'b0},
		// released: position ignored; then a new target restarts the loop
		'{10'd300,  10'd600,  1'b1, 8'd0,   1'b0, 1'b1},
		'{10'd600,  10'd601,  1'b0, 8'd0,   1'b0, 1'b0}
	};

	pipls_pkg::cfg_t                          loop_cfg;
	logic signed [17:0]                       integ_sum;
	logic [pipls_pkg::SAMPLE_BITS:0]          last_target;
	bit                                       released;
	logic [pipls_pkg::COUNT_BITS-1:0]         period_cnt;
	logic [pipls_pkg::SAMPLE_BITS:0]          settle_ref;
	logic signed [pipls_pkg::DRIVE_BITS:0]    drive_now;

	pipls_pkg::result_t drive_expect_q [$];
	int                 fail_count;
	int                 cycle_count;
	int                 gap_pct;
	int                 stall_pct;

	function automatic longint clamp_mag(input longint v, input longint b);
		if (v > b)
			return b;
		if (v < -b)
			return -b;
		return v;
	endfunction

	function automatic longint span(input longint a, input longint b);
		return (a > b) ? a - b : b - a;
	endfunction

	function automatic pipls_pkg::result_t step_loop(
			input logic [pipls_pkg::SAMPLE_BITS-1:0] pos,
			input logic [pipls_pkg::SAMPLE_BITS-1:0] tgt);
		longint err, bound, acc, total, mag, thr;
		pipls_pkg::result_t r;
		if (loop_cfg.enable) begin
			if (last_target != {1'b0, tgt}) begin
				released = 1'b0;
				last_target = {1'b0, tgt};
			end
			if (!released) begin
				err = longint'(tgt) - longint'(pos);
				bound = longint'(loop_cfg.drive_limit) << pipls_pkg::GAIN_FRAC;
				acc = clamp_mag(longint'(integ_sum) + longint'(loop_cfg.int_gain) * err, bound);
				integ_sum = 18'(acc);
				total = clamp_mag(longint'(loop_cfg.prop_gain) * err + acc, bound);
				mag = ((total < 0) ? -total : total) >> pipls_pkg::GAIN_FRAC;
				drive_now = (pipls_pkg::DRIVE_BITS + 1)'((total < 0) ? -mag : mag);
				period_cnt = period_cnt + 1'b1;
				if (period_cnt == loop_cfg.settle_samples) begin
					thr = longint'(loop_cfg.settle_thr);
					if (span(settle_ref, pos) <= thr && span(settle_ref, tgt) < thr &&
							span(pos, tgt) < thr)
						released = 1'b1;
					period_cnt = '0;
					settle_ref = {1'b0, pos};
				end
			end
		end
		if (released) begin
			r = '0;
			r.motor_released = 1'b1;
		end else begin
			mag = (drive_now < 0) ? -longint'(drive_now) : longint'(drive_now);
			r.drive_level = mag[pipls_pkg::DRIVE_BITS-1:0];
			r.drive_reverse = (drive_now > 0);
			r.motor_released = 1'b0;
		end
		return r;
	endfunction

	function automatic pipls_pkg::cfg_t random_cfg();
		pipls_pkg::cfg_t c;
		c.enable = 1'b1;
		c.prop_gain = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2048));
		c.int_gain = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(256));
		c.drive_limit = 8'($urandom_range(1, 255));
		c.settle_thr = 10'($urandom_range(1, 120));
		c.settle_samples = 8'($urandom_range(1, 20));
		return c;
	endfunction

	function automatic logic [pipls_pkg::SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return 10'($urandom);
		endcase
	endfunction

	task automatic send_sample(input logic [pipls_pkg::SAMPLE_BITS-1:0] pos,
			input logic [pipls_pkg::SAMPLE_BITS-1:0] tgt, input bit use_typed,
			input pipls_pkg::result_t typed_res);
		pipls_pkg::result_t predicted;
		while ($urandom_range(99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= pipls_pkg::IN_DATA_BITS'({tgt, pos});
		do
			@(posedge clk);
		while (!s_axis_tready);
		predicted = step_loop(pos, tgt);
		drive_expect_q.push_back(use_typed ? typed_res : predicted);
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (drive_expect_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_regs(input pipls_pkg::cfg_t c);
		cfg_we <= 1'b1;
		cfg_addr <= pipls_pkg::REG_ENABLE;
		cfg_wdata <= pipls_pkg::CFG_BITS'(c.enable);
		@(posedge clk);
		cfg_addr <= pipls_pkg::REG_PROP_GAIN;
		cfg_wdata <= pipls_pkg::CFG_BITS'(c.prop_gain);
		@(posedge clk);
		cfg_addr <= pipls_pkg::REG_INT_GAIN;
		cfg_wdata <= pipls_pkg::CFG_BITS'(c.int_gain);
		@(posedge clk);
		cfg_addr <= pipls_pkg::REG_DRIVE_LIMIT;
		cfg_wdata <= pipls_pkg::CFG_BITS'(c.drive_limit);
		@(posedge clk);
		cfg_addr <= pipls_pkg::REG_SETTLE_THR;
		cfg_wdata <= pipls_pkg::CFG_BITS'(c.settle_thr);
		@(posedge clk);
		cfg_addr <= pipls_pkg::REG_SETTLE_SAMPLES;
		cfg_wdata <= pipls_pkg::CFG_BITS'(c.settle_samples);
		@(posedge clk);
		cfg_we <= 1'b0;
		loop_cfg = c;
	endtask

	// mostly a held target with the position closing in on it, some noise words
	task automatic run_phase(input int n);
		int sent, run_len, nxt;
		logic [pipls_pkg::SAMPLE_BITS-1:0] pos, tgt;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(9) < 2) begin
				send_sample(10'($urandom), 10'($urandom), 1'b0, '0);
				sent++;
			end else begin
				tgt = pick_sample();
				pos = pick_sample();
				run_len = $urandom_range(4, 40);
				for (int k = 0; k < run_len && sent < n; k++) begin
					send_sample(pos, tgt, 1'b0, '0);
					sent++;
					nxt = int'(pos) + (int'(tgt) - int'(pos)) / 3 +
						int'($urandom_range(4)) - 2;
					if (nxt < 0)
						nxt = 0;
					else if (nxt > 1023)
						nxt = 1023;
					pos = 10'(nxt);
				end
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** pi_position_loop_with_settle: FAILED **");
		$finish;
	end

	initial begin : result_check
		pipls_pkg::result_t got, want;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				got.drive_level = m_axis_tdata[pipls_pkg::DRIVE_BITS-1:0];
				got.drive_reverse = m_axis_tdata[pipls_pkg::OUT_REV_BIT];
				got.motor_released = m_axis_tdata[pipls_pkg::OUT_REL_BIT];
				if (drive_expect_q.size() == 0) begin
					$display("%0t: unexpected word, actual level %0d reverse %0b released %0b",
						$time, got.drive_level, got.drive_reverse, got.motor_released);
					fail_count++;
				end else begin
					want = drive_expect_q.pop_front();
					if (got.drive_level !== want.drive_level ||
							got.drive_reverse !== want.drive_reverse ||
							got.motor_released !== want.motor_released) begin
						$display("%0t: expected level %0d reverse %0b released %0b, %s %0d %0b %0b",
							$time, want.drive_level, want.drive_reverse, want.motor_released,
							"actual", got.drive_level, got.drive_reverse, got.motor_released);
						fail_count++;
					end
				end
			end
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin : stimulus
		pipls_pkg::cfg_t c;
		int n;
		fail_count = 0;
		gap_pct = 35;
		stall_pct = 35;
		loop_cfg = pipls_pkg::CFG_RESET;
		integ_sum = '0;
		last_target = '1;
		released = 1'b0;
		period_cnt = '0;
		settle_ref = '1;
		drive_now = '0;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		cfg_we <= 1'b0;
		cfg_addr <= pipls_pkg::REG_ENABLE;
		cfg_wdata <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (DIR_ROWS[i])
			send_sample(DIR_ROWS[i].pos, DIR_ROWS[i].tgt, DIR_ROWS[i].typed,
				{DIR_ROWS[i].lvl, DIR_ROWS[i].rev, DIR_ROWS[i].rel});

		for (int ph = 0; ph < 10; ph++) begin
			c = random_cfg();
			n = 40;
			gap_pct = 35;
			stall_pct = 35;
			case (ph)
				1: begin
					c.prop_gain = '1;
					c.int_gain = '1;
					c.drive_limit = 8'd255;
					c.settle_samples = 8'd255;
				end
				2: begin
					c.prop_gain = '0;
					c.drive_limit = 8'd1;
					c.settle_thr = 10'd1023;
					c.settle_samples = 8'd1;
				end
				3: c.drive_limit = '0;
				4: c.settle_thr = '0;
				5: c.enable = 1'b0;
				6: begin
					c.settle_samples = 8'd200;
					n = 80;
					gap_pct = 0;
					stall_pct = 0;
				end
				7: begin
					// count is already past zero, so it has to wrap
					c.settle_samples = '0;
					n = 200;
				end
				default: ;
			endcase
			wait_idle();
			load_regs(c);
			run_phase(n);
		end

		wait_idle();
		if (fail_count == 0)
			$display("** pi_position_loop_with_settle: PASSED **");
		else
			$display("** pi_position_loop_with_settle: FAILED **");
		$finish;
	end

endmodule
